FILE: design/nhr_pkg.sv
// Shared constants, codes and types of the next-hop resolver.
package nhr_pkg;

    localparam int ROUTE_DEPTH = 16;
    localparam int CACHE_DEPTH = 16;
    localparam int PORT_COUNT  = 8;

    localparam int ROUTE_AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int CACHE_AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int MAX_DEPTH = (ROUTE_DEPTH > CACHE_DEPTH) ? ROUTE_DEPTH : CACHE_DEPTH;
    localparam int SCAN_W = $clog2(MAX_DEPTH + 1);

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;
    localparam int SLOT_W = 4;
    localparam int TTL_W  = 16;
    localparam int EXP_W  = 5;

    localparam logic [TTL_W-1:0] TTL_RESET = 16'd30;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ENTRY_TTL = 1'b0;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 96;

    typedef enum logic [1:0] {
        KIND_ROUTE_WR = 2'd0,
        KIND_RESOLVE  = 2'd1,
        KIND_LEARN    = 2'd2,
        KIND_TICK     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_RWRITE = 3'd1,
        S_RSCAN  = 3'd2,
        S_CSCAN  = 3'd3,
        S_LEARN  = 3'd4,
        S_TICK   = 3'd5,
        S_DONE   = 3'd6
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [IP_W-1:0]    subnet;
        logic [IP_W-1:0]    mask;
        logic [IP_W-1:0]    gateway;
        logic [PORT_W-1:0]  port_id;
        logic               route_valid;
        logic [IP_W-1:0]    ip_addr;
        logic [MAC_W-1:0]   mac_addr;
    } t_item;

    typedef struct packed {
        logic               route_found;
        logic [IP_W-1:0]    next_hop;
        logic [PORT_W-1:0]  out_port;
        logic               mac_found;
        logic [MAC_W-1:0]   dest_mac;
        logic               cache_full;
        logic [EXP_W-1:0]   expired_count;
    } t_result;

    typedef struct packed {
        logic                en;
        logic [ROUTE_AW-1:0] addr;
        logic [IP_W-1:0]     subnet;
        logic [IP_W-1:0]     mask;
        logic [IP_W-1:0]     gateway;
        logic [PORT_W-1:0]   port_id;
        logic                valid;
    } t_route_wr;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    subnet;
        logic [IP_W-1:0]    mask;
        logic [IP_W-1:0]    gateway;
        logic [PORT_W-1:0]  port_id;
    } t_route_rd;

    typedef struct packed {
        logic                en;
        logic [CACHE_AW-1:0] addr;
        logic [IP_W-1:0]     ip;
        logic [MAC_W-1:0]    mac;
        logic [TTL_W-1:0]    life;
    } t_cache_wr;

    typedef struct packed {
        logic                en;
        logic [CACHE_AW-1:0] addr;
        logic                clear;
        logic [TTL_W-1:0]    life;
    } t_cache_upd;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [TTL_W-1:0]   life;
    } t_cache_rd;

endpackage

FILE: design/nhr_route_mem.sv
// Route table storage: entry memories with registered read, valid bits in flops.
module nhr_route_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nhr_pkg::t_route_wr            i_wr,
    input  logic [nhr_pkg::ROUTE_AW-1:0]  i_raddr,
    output nhr_pkg::t_route_rd            o_rd
);

    logic [nhr_pkg::IP_W-1:0]   mem_subnet  [nhr_pkg::ROUTE_DEPTH];
    logic [nhr_pkg::IP_W-1:0]   mem_mask    [nhr_pkg::ROUTE_DEPTH];
    logic [nhr_pkg::IP_W-1:0]   mem_gateway [nhr_pkg::ROUTE_DEPTH];
    logic [nhr_pkg::PORT_W-1:0] mem_port    [nhr_pkg::ROUTE_DEPTH];
    logic [nhr_pkg::ROUTE_DEPTH-1:0] r_valid;
    nhr_pkg::t_route_rd r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_subnet[i_wr.addr]  <= i_wr.subnet;
            mem_mask[i_wr.addr]    <= i_wr.mask;
            mem_gateway[i_wr.addr] <= i_wr.gateway;
            mem_port[i_wr.addr]    <= i_wr.port_id;
        end
        r_rd.subnet  <= mem_subnet[i_raddr];
        r_rd.mask    <= mem_mask[i_raddr];
        r_rd.gateway <= mem_gateway[i_raddr];
        r_rd.port_id <= mem_port[i_raddr];
        r_rd.valid   <= r_valid[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= i_wr.valid;
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: design/nhr_cache_mem.sv
// Address cache storage: IP, MAC and lifetime memories, valid bits in flops.
module nhr_cache_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nhr_pkg::t_cache_wr            i_wr,
    input  nhr_pkg::t_cache_upd           i_upd,
    input  logic [nhr_pkg::CACHE_AW-1:0]  i_raddr,
    output nhr_pkg::t_cache_rd            o_rd,
    output logic [nhr_pkg::CACHE_DEPTH-1:0] o_valid
);

    logic [nhr_pkg::IP_W-1:0]  mem_ip   [nhr_pkg::CACHE_DEPTH];
    logic [nhr_pkg::MAC_W-1:0] mem_mac  [nhr_pkg::CACHE_DEPTH];
    logic [nhr_pkg::TTL_W-1:0] mem_life [nhr_pkg::CACHE_DEPTH];
    logic [nhr_pkg::CACHE_DEPTH-1:0] r_valid;
    nhr_pkg::t_cache_rd r_rd;

    // learn and tick never overlap, so one life write port serves both
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_ip[i_wr.addr]   <= i_wr.ip;
            mem_mac[i_wr.addr]  <= i_wr.mac;
            mem_life[i_wr.addr] <= i_wr.life;
        end else if (i_upd.en && !i_upd.clear) begin
            mem_life[i_upd.addr] <= i_upd.life;
        end
        r_rd.ip    <= mem_ip[i_raddr];
        r_rd.mac   <= mem_mac[i_raddr];
        r_rd.life  <= mem_life[i_raddr];
        r_rd.valid <= r_valid[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_upd.en && i_upd.clear) begin
                r_valid[i_upd.addr] <= 1'b0;
            end
        end
    end

    assign o_rd    = r_rd;
    assign o_valid = r_valid;

endmodule

FILE: design/nhr_ctrl.sv
// Sequencer and shared comparator: walks route table and cache one entry per cycle.
module nhr_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  nhr_pkg::t_item                    i_item,
    input  logic [nhr_pkg::TTL_W-1:0]         i_ttl,
    input  logic                              i_out_free,
    input  nhr_pkg::t_route_rd                i_route_rd,
    input  nhr_pkg::t_cache_rd                i_cache_rd,
    input  logic [nhr_pkg::CACHE_DEPTH-1:0]   i_cache_valid,
    output logic                              o_ready,
    output logic                              o_done,
    output nhr_pkg::t_result                  o_result,
    output nhr_pkg::t_route_wr                o_route_wr,
    output logic [nhr_pkg::ROUTE_AW-1:0]      o_route_raddr,
    output nhr_pkg::t_cache_wr                o_cache_wr,
    output nhr_pkg::t_cache_upd               o_cache_upd,
    output logic [nhr_pkg::CACHE_AW-1:0]      o_cache_raddr
);

    nhr_pkg::t_state  r_state, n_state;
    nhr_pkg::t_item   r_item, n_item;
    nhr_pkg::t_result r_res, n_res;
    logic [nhr_pkg::IP_W-1:0]   r_hop, n_hop;
    logic [nhr_pkg::SCAN_W-1:0] r_idx, n_idx;
    logic [nhr_pkg::SCAN_W-1:0] r_cidx, n_cidx;
    logic r_cv, n_cv;

    // shared comparator
    logic [nhr_pkg::IP_W-1:0] cmp_a, cmp_b;
    logic cmp_eq, cmp_le;
    logic route_hit, route_last, cache_hit, cache_last;
    logic route_more, cache_more, learn_free;
    logic [nhr_pkg::IP_W-1:0] hit_hop;

    always_comb begin
        case (r_state)
            nhr_pkg::S_RSCAN: begin
                cmp_a = r_item.ip_addr & i_route_rd.mask;
                cmp_b = i_route_rd.subnet;
            end
            nhr_pkg::S_CSCAN: begin
                cmp_a = i_cache_rd.ip;
                cmp_b = r_hop;
            end
            nhr_pkg::S_TICK: begin
                cmp_a = nhr_pkg::IP_W'(i_cache_rd.life);
                cmp_b = nhr_pkg::IP_W'(1);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
        cmp_eq = (cmp_a == cmp_b);
        cmp_le = (cmp_a <= cmp_b);
    end

    assign route_more = (r_idx < nhr_pkg::SCAN_W'(nhr_pkg::ROUTE_DEPTH));
    assign cache_more = (r_idx < nhr_pkg::SCAN_W'(nhr_pkg::CACHE_DEPTH));
    assign route_hit  = r_cv && i_route_rd.valid && cmp_eq;
    assign cache_hit  = r_cv && i_cache_rd.valid && cmp_eq;
    assign route_last = r_cv && (r_cidx == nhr_pkg::SCAN_W'(nhr_pkg::ROUTE_DEPTH - 1));
    assign cache_last = r_cv && (r_cidx == nhr_pkg::SCAN_W'(nhr_pkg::CACHE_DEPTH - 1));
    assign learn_free = !i_cache_valid[r_idx[nhr_pkg::CACHE_AW-1:0]];
    assign hit_hop    = (i_route_rd.gateway != '0) ? i_route_rd.gateway : r_item.ip_addr;

    assign o_route_raddr = r_idx[nhr_pkg::ROUTE_AW-1:0];
    assign o_cache_raddr = r_idx[nhr_pkg::CACHE_AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nhr_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_item.kind)
                        nhr_pkg::KIND_ROUTE_WR: n_state = nhr_pkg::S_RWRITE;
                        nhr_pkg::KIND_RESOLVE:  n_state = nhr_pkg::S_RSCAN;
                        nhr_pkg::KIND_LEARN:    n_state = nhr_pkg::S_LEARN;
                        nhr_pkg::KIND_TICK:     n_state = nhr_pkg::S_TICK;
                        default:                n_state = nhr_pkg::S_IDLE;
                    endcase
                end
            end
            nhr_pkg::S_RWRITE: n_state = nhr_pkg::S_DONE;
            nhr_pkg::S_RSCAN: begin
                if (route_hit) begin
                    n_state = nhr_pkg::S_CSCAN;
                end else if (route_last) begin
                    n_state = nhr_pkg::S_DONE;
                end
            end
            nhr_pkg::S_CSCAN: begin
                if (cache_hit || cache_last) begin
                    n_state = nhr_pkg::S_DONE;
                end
            end
            nhr_pkg::S_LEARN: begin
                if (learn_free ||
                    (r_idx == nhr_pkg::SCAN_W'(nhr_pkg::CACHE_DEPTH - 1))) begin
                    n_state = nhr_pkg::S_DONE;
                end
            end
            nhr_pkg::S_TICK: begin
                if (cache_last) begin
                    n_state = nhr_pkg::S_DONE;
                end
            end
            nhr_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = nhr_pkg::S_IDLE;
                end
            end
            default: n_state = nhr_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_item      = r_item;
        n_res       = r_res;
        n_hop       = r_hop;
        n_idx       = r_idx;
        n_cidx      = r_idx;
        n_cv        = 1'b0;
        o_ready     = 1'b0;
        o_done      = 1'b0;
        o_route_wr  = '0;
        o_cache_wr  = '0;
        o_cache_upd = '0;
        case (r_state)
            nhr_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_item = i_item;
                    n_res  = '0;
                    n_idx  = '0;
                end
            end
            nhr_pkg::S_RWRITE: begin
                o_route_wr.en = (int'(r_item.slot) < nhr_pkg::ROUTE_DEPTH) &&
                                (int'(r_item.port_id) < nhr_pkg::PORT_COUNT);
                o_route_wr.addr    = nhr_pkg::ROUTE_AW'(r_item.slot);
                o_route_wr.subnet  = r_item.subnet;
                o_route_wr.mask    = r_item.mask;
                o_route_wr.gateway = r_item.gateway;
                o_route_wr.port_id = r_item.port_id;
                o_route_wr.valid   = r_item.route_valid;
            end
            nhr_pkg::S_RSCAN: begin
                n_cv  = route_more;
                n_idx = r_idx + nhr_pkg::SCAN_W'(route_more);
                if (route_hit) begin
                    n_res.route_found = 1'b1;
                    n_res.next_hop    = hit_hop;
                    n_res.out_port    = i_route_rd.port_id;
                    n_hop             = hit_hop;
                    n_cv              = 1'b0;
                    n_idx             = '0;
                end
            end
            nhr_pkg::S_CSCAN: begin
                n_cv  = cache_more;
                n_idx = r_idx + nhr_pkg::SCAN_W'(cache_more);
                if (cache_hit) begin
                    n_res.mac_found = 1'b1;
                    n_res.dest_mac  = i_cache_rd.mac;
                end
            end
            nhr_pkg::S_LEARN: begin
                n_idx = r_idx + nhr_pkg::SCAN_W'(1);
                if (learn_free) begin
                    o_cache_wr.en   = 1'b1;
                    o_cache_wr.addr = r_idx[nhr_pkg::CACHE_AW-1:0];
                    o_cache_wr.ip   = r_item.ip_addr;
                    o_cache_wr.mac  = r_item.mac_addr;
                    o_cache_wr.life = i_ttl;
                end else if (r_idx == nhr_pkg::SCAN_W'(nhr_pkg::CACHE_DEPTH - 1)) begin
                    n_res.cache_full = 1'b1;
                end
            end
            nhr_pkg::S_TICK: begin
                n_cv  = cache_more;
                n_idx = r_idx + nhr_pkg::SCAN_W'(cache_more);
                if (r_cv && i_cache_rd.valid) begin
                    o_cache_upd.en    = 1'b1;
                    o_cache_upd.addr  = r_cidx[nhr_pkg::CACHE_AW-1:0];
                    o_cache_upd.clear = cmp_le;
                    o_cache_upd.life  = i_cache_rd.life - nhr_pkg::TTL_W'(1);
                    if (cmp_le) begin
                        n_res.expired_count = r_res.expired_count + nhr_pkg::EXP_W'(1);
                    end
                end
            end
            nhr_pkg::S_DONE: begin
                o_done = i_out_free;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nhr_pkg::S_IDLE;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cv    <= n_cv;
        end
        r_item <= n_item;
        r_res  <= n_res;
        r_hop  <= n_hop;
        r_idx  <= n_idx;
        r_cidx <= n_cidx;
    end

    assign o_result = r_res;

endmodule

FILE: design/next_hop_resolver.sv
// Top level of the next-hop resolver: stream ports, APB register, output register.
//
// Next-hop resolver. Each request on the slave stream is one of four kinds
// (tuser): route write, resolve, learn or tick, and gives exactly one result on
// the master stream. A resolve finds the lowest-indexed valid route whose
// (ip & mask) equals its subnet, takes its gateway (or the destination itself
// when the gateway is zero) as next hop, and then looks the next hop up in the
// address cache. A learn puts the IP/MAC pair into the lowest free cache slot
// with a lifetime of entry_ttl (zero counts as one) or flags cache_full. A tick
// ages every cached entry and reports how many expired. Route and cache valid
// bits clear at reset; entry contents do not need to. Requests are taken one at
// a time and tready is low while one is being worked on. A single 32-bit
// comparator is stepped over the table and the cache, one entry per cycle
// behind a registered memory read. A finished result sits in an output
// register, so a new request is accepted while it waits for tready.
// entry_ttl lies at APB address 0; it must only be written while no request
// is in flight.
module next_hop_resolver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // {mac_addr, ip_addr, route_valid, port_id, gateway, mask, subnet, slot}
    // slot [3:0], subnet [35:4], mask [67:36], gateway [99:68],
    // port_id [102:100], route_valid [103], ip_addr [135:104], mac_addr [183:136]
    input  logic [nhr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  logic [1:0]                      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // route_found [0], next_hop [32:1], out_port [35:33], mac_found [36],
    // dest_mac [84:37], cache_full [85], expired_count [90:86], zero [95:91]
    output logic [nhr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nhr_pkg::APB_AW-1:0]      paddr,
    input  logic [nhr_pkg::APB_DW-1:0]      pwdata,
    output logic [nhr_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    nhr_pkg::t_item      item;
    nhr_pkg::t_result    res;
    nhr_pkg::t_route_wr  route_wr;
    nhr_pkg::t_route_rd  route_rd;
    nhr_pkg::t_cache_wr  cache_wr;
    nhr_pkg::t_cache_upd cache_upd;
    nhr_pkg::t_cache_rd  cache_rd;
    logic [nhr_pkg::CACHE_DEPTH-1:0] cache_valid;
    logic [nhr_pkg::ROUTE_AW-1:0]    route_raddr;
    logic [nhr_pkg::CACHE_AW-1:0]    cache_raddr;
    logic [nhr_pkg::TTL_W-1:0]       r_ttl, ttl_eff;
    logic [nhr_pkg::M_TDATA_W-1:0]   r_m_data;
    logic r_m_valid;
    logic ctrl_ready, ctrl_done, out_free, req_accept, cfg_wr;

    // unpack request
    assign item.kind        = nhr_pkg::t_kind'(s_axis_tuser);
    assign item.slot        = s_axis_tdata[3:0];
    assign item.subnet      = s_axis_tdata[35:4];
    assign item.mask        = s_axis_tdata[67:36];
    assign item.gateway     = s_axis_tdata[99:68];
    assign item.port_id     = s_axis_tdata[102:100];
    assign item.route_valid = s_axis_tdata[103];
    assign item.ip_addr     = s_axis_tdata[135:104];
    assign item.mac_addr    = s_axis_tdata[183:136];

    assign s_axis_tready = ctrl_ready;
    assign req_accept    = s_axis_tvalid && ctrl_ready;

    // config register; word index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= nhr_pkg::TTL_RESET;
        end else if (cfg_wr && (paddr[2] == nhr_pkg::REG_ENTRY_TTL)) begin
            r_ttl <= pwdata[nhr_pkg::TTL_W-1:0];
        end
    end

    assign prdata  = (paddr[2] == nhr_pkg::REG_ENTRY_TTL) ?
                     nhr_pkg::APB_DW'(r_ttl) : '0;
    assign ttl_eff = (r_ttl == '0) ? nhr_pkg::TTL_W'(1) : r_ttl;

    // output register parts the result from the sequencer
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctrl_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (ctrl_done) begin
            r_m_data <= {5'b0, res.expired_count, res.cache_full, res.dest_mac,
                         res.mac_found, res.out_port, res.next_hop, res.route_found};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    nhr_route_mem u_route_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (route_wr),
        .i_raddr (route_raddr),
        .o_rd    (route_rd)
    );

    nhr_cache_mem u_cache_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cache_wr),
        .i_upd   (cache_upd),
        .i_raddr (cache_raddr),
        .o_rd    (cache_rd),
        .o_valid (cache_valid)
    );

    nhr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (req_accept),
        .i_item        (item),
        .i_ttl         (ttl_eff),
        .i_out_free    (out_free),
        .i_route_rd    (route_rd),
        .i_cache_rd    (cache_rd),
        .i_cache_valid (cache_valid),
        .o_ready       (ctrl_ready),
        .o_done        (ctrl_done),
        .o_result      (res),
        .o_route_wr    (route_wr),
        .o_route_raddr (route_raddr),
        .o_cache_wr    (cache_wr),
        .o_cache_upd   (cache_upd),
        .o_cache_raddr (cache_raddr)
    );

`ifndef SYNTH
    // a result is only handed over when the output register can take it
    a_done_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_done |-> out_free)
        else $error("result produced while output register busy");

    // one request in flight: after an accept the sequencer is busy
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> !s_axis_tready)
        else $error("request accepted while sequencer busy");

    // no route means no next hop and no cache lookup
    a_no_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_done && !res.route_found) |->
            (res.next_hop == '0 && !res.mac_found && res.dest_mac == '0))
        else $error("resolve fields set without a route");

    // a cache write and a lifetime update never coincide
    a_cache_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cache_wr.en && cache_upd.en))
        else $error("learn and tick collide on cache");
`endif

endmodule

FILE: bench/next_hop_checker.sv
`timescale 1ns / 100ps
// Result checker of the next-hop resolver: tracks requests, predicts results, compares them.
module next_hop_checker
    import nhr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    // shadow of the route table
    logic [IP_W-1:0]   rt_subnet  [ROUTE_DEPTH];
    logic [IP_W-1:0]   rt_mask    [ROUTE_DEPTH];
    logic [IP_W-1:0]   rt_gateway [ROUTE_DEPTH];
    logic [PORT_W-1:0] rt_port    [ROUTE_DEPTH];
    logic              rt_valid   [ROUTE_DEPTH];
    // shadow of the address cache
    logic [IP_W-1:0]   arp_ip     [CACHE_DEPTH];
    logic [MAC_W-1:0]  arp_mac    [CACHE_DEPTH];
    logic [TTL_W-1:0]  arp_life   [CACHE_DEPTH];
    logic              arp_valid  [CACHE_DEPTH];
    logic [TTL_W-1:0]  ttl_cfg;

    t_result           hop_results_q [$];
    int                mismatches = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [MAC_W-1:0] got,
                               input logic [MAC_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic void clear_state();
        for (int i = 0; i < ROUTE_DEPTH; i++)
            rt_valid[i] = 1'b0;
        for (int c = 0; c < CACHE_DEPTH; c++) begin
            arp_valid[c] = 1'b0;
            arp_life[c]  = '0;
        end
        ttl_cfg = TTL_RESET;
    endfunction

    // Applies one request to the shadow state and returns the result it must give.
    function automatic t_result apply_request(input t_kind kind,
                                              input logic [S_TDATA_W-1:0] d);
        t_result           r;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   subnet;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   gateway;
        logic [PORT_W-1:0] port;
        logic              valid;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   hop;
        bit                hit;
        r       = '0;
        slot    = d[3:0];
        subnet  = d[35:4];
        mask    = d[67:36];
        gateway = d[99:68];
        port    = d[102:100];
        valid   = d[103];
        ip      = d[135:104];
        mac     = d[183:136];
        case (kind)
            KIND_ROUTE_WR: begin
                if (int'(slot) < ROUTE_DEPTH && int'(port) < PORT_COUNT) begin
                    rt_subnet[slot]  = subnet;
                    rt_mask[slot]    = mask;
                    rt_gateway[slot] = gateway;
                    rt_port[slot]    = port;
                    rt_valid[slot]   = valid;
                end
            end
            KIND_RESOLVE: begin
                hit = 1'b0;
                for (int i = 0; i < ROUTE_DEPTH; i++) begin
                    if (!hit && rt_valid[i] && ((ip & rt_mask[i]) == rt_subnet[i])) begin
                        hit = 1'b1;
                        hop = (rt_gateway[i] != '0) ? rt_gateway[i] : ip;
                        r.route_found = 1'b1;
                        r.next_hop    = hop;
                        r.out_port    = rt_port[i];
                        // lowest-indexed valid cache hit wins
                        for (int c = 0; c < CACHE_DEPTH; c++) begin
                            if (!r.mac_found && arp_valid[c] && arp_ip[c] == hop) begin
                                r.mac_found = 1'b1;
                                r.dest_mac  = arp_mac[c];
                            end
                        end
                    end
                end
            end
            KIND_LEARN: begin
                r.cache_full = 1'b1;
                for (int c = 0; c < CACHE_DEPTH; c++) begin
                    if (r.cache_full && !arp_valid[c]) begin
                        arp_ip[c]    = ip;
                        arp_mac[c]   = mac;
                        arp_life[c]  = (ttl_cfg != '0) ? ttl_cfg : TTL_W'(1);
                        arp_valid[c] = 1'b1;
                        r.cache_full = 1'b0;
                    end
                end
            end
            default: begin
                for (int c = 0; c < CACHE_DEPTH; c++) begin
                    if (arp_valid[c]) begin
                        if (arp_life[c] <= TTL_W'(1)) begin
                            arp_life[c]  = '0;
                            arp_valid[c] = 1'b0;
                            r.expired_count = r.expired_count + 1'b1;
                        end else begin
                            arp_life[c] = arp_life[c] - 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            hop_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[APB_AW-1:2] == REG_ENTRY_TTL)
                ttl_cfg = i_pwdata[TTL_W-1:0];
            if (i_s_tvalid && i_s_tready) begin
                want = apply_request(t_kind'(i_s_tuser), i_s_tdata);
                hop_results_q.insert(hop_results_q.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.route_found   = i_m_tdata[0];
                got.next_hop      = i_m_tdata[32:1];
                got.out_port      = i_m_tdata[35:33];
                got.mac_found     = i_m_tdata[36];
                got.dest_mac      = i_m_tdata[84:37];
                got.cache_full    = i_m_tdata[85];
                got.expired_count = i_m_tdata[90:86];
                if (hop_results_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = hop_results_q.pop_front();
                    check_field("route_found", got.route_found, want.route_found);
                    check_field("next_hop", got.next_hop, want.next_hop);
                    check_field("out_port", got.out_port, want.out_port);
                    check_field("mac_found", got.mac_found, want.mac_found);
                    check_field("dest_mac", got.dest_mac, want.dest_mac);
                    check_field("cache_full", got.cache_full, want.cache_full);
                    check_field("expired_count", got.expired_count, want.expired_count);
                    check_field("pad bits", i_m_tdata[95:91], '0);
                end
            end
        end
        o_pending    <= hop_results_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: bench/next_hop_resolver_tb.sv
`timescale 1ns / 100ps
// Testbench top of the next-hop resolver: clock, reset, stimulus, stalls and verdict.
module next_hop_resolver_tb;
    import nhr_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 4;
    localparam int HOLD_CYCLES      = 300;      // long receiver hold-off
    localparam int RANDOM_PER_PHASE = 250;
    localparam int PHASES           = 6;
    localparam int DRAIN_CYCLES     = 64;       // well past the longest resolve
    localparam int HOP_POOL_MAX     = 24;
    localparam int REG_UNUSED       = 1;        // index with no register behind it
    localparam int LIMIT_NS         = 8_000_000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int  fail_count;
    int  pending;
    int  idle_pct  = 0;     // sender: chance of a gap before a request
    int  stall_pct = 0;     // receiver: chance of tready low in a cycle
    bit  hold_req  = 1'b0;
    bit  hold_done = 1'b0;

    // What the stimulus has written to the route table, so resolves can aim at
    // existing routes; and a pool of addresses worth learning and resolving.
    logic [IP_W-1:0] aim_net  [ROUTE_DEPTH];
    logic [IP_W-1:0] aim_mask [ROUTE_DEPTH];
    bit              aim_set  [ROUTE_DEPTH];
    logic [IP_W-1:0] hop_pool [$];

    always #(CLK_HALF) i_clk = ~i_clk;

    next_hop_resolver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    next_hop_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, plus one long hold-off on request so the
    // output register fills and the block backs up its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // APB write: setup cycle, access cycle, done at the edge with pready high.
    task automatic write_reg(input int idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drives one request and returns at the edge that accepted it; tvalid is
    // left high so back-to-back requests need no dead cycle.
    task automatic send_req(input t_item it);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tdata  <= {it.mac_addr, it.ip_addr, it.route_valid, it.port_id,
                          it.gateway, it.mask, it.subnet, it.slot};
        s_axis_tuser  <= it.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sender pause: drop tvalid and wait until every result is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // All fields random; the kind-specific helpers overwrite what they use.
    function automatic t_item noise_item(input t_kind k);
        t_item it;
        it.kind        = k;
        it.slot        = SLOT_W'($urandom());
        it.subnet      = $urandom();
        it.mask        = $urandom();
        it.gateway     = $urandom();
        it.port_id     = PORT_W'($urandom());
        it.route_valid = 1'($urandom());
        it.ip_addr     = $urandom();
        it.mac_addr    = {16'($urandom()), 32'($urandom())};
        return it;
    endfunction

    function automatic void remember_hop(input logic [IP_W-1:0] ip);
        hop_pool.insert(hop_pool.size(), ip);
        if (hop_pool.size() > HOP_POOL_MAX)
            void'(hop_pool.pop_front());
    endfunction

    task automatic send_route(input logic [SLOT_W-1:0] slot, input logic [IP_W-1:0] subnet,
                              input logic [IP_W-1:0] mask, input logic [IP_W-1:0] gw,
                              input logic [PORT_W-1:0] port, input logic valid);
        t_item it;
        it             = noise_item(KIND_ROUTE_WR);
        it.slot        = slot;
        it.subnet      = subnet;
        it.mask        = mask;
        it.gateway     = gw;
        it.port_id     = port;
        it.route_valid = valid;
        aim_net[slot]  = subnet;
        aim_mask[slot] = mask;
        aim_set[slot]  = 1'b1;
        if (gw != '0)
            remember_hop(gw);
        send_req(it);
    endtask

    task automatic send_resolve(input logic [IP_W-1:0] ip);
        t_item it;
        it         = noise_item(KIND_RESOLVE);
        it.ip_addr = ip;
        remember_hop(ip);
        send_req(it);
    endtask

    task automatic send_learn(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        t_item it;
        it          = noise_item(KIND_LEARN);
        it.ip_addr  = ip;
        it.mac_addr = mac;
        send_req(it);
    endtask

    task automatic send_tick();
        send_req(noise_item(KIND_TICK));
    endtask

    function automatic logic [IP_W-1:0] pool_or_random();
        if (hop_pool.size() != 0 && $urandom_range(9) < 7)
            return hop_pool[$urandom_range(hop_pool.size() - 1)];
        return $urandom();
    endfunction

    // One random request. Mostly well-formed: prefix masks with aligned
    // subnets, resolves aimed inside written routes, learns of addresses
    // that show up as next hops.
    task automatic random_request();
        int              pick;
        int              len;
        int              s;
        logic [IP_W-1:0] mask;
        logic [IP_W-1:0] subnet;
        logic [IP_W-1:0] gw;
        logic [IP_W-1:0] ip;
        pick = $urandom_range(99);
        if (pick < 15) begin
            len    = $urandom_range(32);
            mask   = ($urandom_range(9) < 8) ? ~(32'hFFFF_FFFF >> len) : $urandom();
            subnet = ($urandom_range(99) < 85) ? ($urandom() & mask) : $urandom();
            s      = $urandom_range(9);
            if (s < 3)
                gw = '0;                    // deliver directly
            else if (s < 8)
                gw = pool_or_random();
            else
                gw = $urandom();
            send_route(SLOT_W'($urandom()), subnet, mask, gw, PORT_W'($urandom()),
                       $urandom_range(99) < 85);
        end else if (pick < 60) begin
            s = $urandom_range(ROUTE_DEPTH - 1);
            if (aim_set[s] && $urandom_range(9) < 7)
                ip = (aim_net[s] & aim_mask[s]) | ($urandom() & ~aim_mask[s]);
            else
                ip = pool_or_random();
            send_resolve(ip);
        end else if (pick < 85) begin
            send_learn(pool_or_random(), {16'($urandom()), 32'($urandom())});
        end else begin
            send_tick();
        end
    endtask

    initial begin
        logic [TTL_W-1:0] ttl;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A write to an empty address must leave entry_ttl alone; then a short
        // lifetime so the directed ticks expire the cache.
        write_reg(REG_UNUSED, $urandom());
        write_reg(int'(REG_ENTRY_TTL), {16'($urandom()), 16'd2});

        // Directed requests.
        send_resolve(32'h0000_0000);                                    // empty table
        send_route(4'd0, '0, '0, '0, 3'd7, 1'b1);                       // default, direct
        send_resolve(32'hFFFF_FFFF);                                    // hop is ip
        send_learn(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_learn(32'hFFFF_FFFF, 48'h0);                               // duplicate
        send_resolve(32'hFFFF_FFFF);                                    // first copy wins
        send_route(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 1'b1);
        send_route(4'd0, '0, '0, '0, 3'd7, 1'b0);                       // invalidate
        send_resolve(32'hFFFF_FFFF);                                    // via last slot
        send_resolve(32'h0000_0000);                                    // no route
        repeat (CACHE_DEPTH - 2) send_learn($urandom(), {16'($urandom()), 32'($urandom())});
        send_learn($urandom(), {16'($urandom()), 32'($urandom())});    // cache full
        send_tick();                                                    // nothing expires
        send_tick();                                                    // whole cache expires
        send_resolve(32'hFFFF_FFFF);                                    // route, no mac

        for (int p = 0; p < PHASES; p++) begin
            // registers only change with nothing in flight
            wait_drained();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            case (p)
                0: ttl = TTL_RESET;
                1: ttl = 16'd1;
                2: ttl = 16'd0;         // treated as one
                3: ttl = 16'hFFFF;
                4: ttl = 16'd3;
                default: ttl = TTL_W'($urandom_range(2, 12));
            endcase
            write_reg(int'(REG_ENTRY_TTL), {16'($urandom()), ttl});
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 0 && n == RANDOM_PER_PHASE / 3)
                    hold_req = 1'b1;
                random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/nhr_pkg.sv
design/nhr_route_mem.sv
design/nhr_cache_mem.sv
design/nhr_ctrl.sv
design/next_hop_resolver.sv
bench/next_hop_checker.sv
bench/next_hop_resolver_tb.sv
